@@ sv/wavhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared tags, status codes and the item and result types of the parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [31:0] FmtMin  = 32'd16;

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusNoRiff    = 3'd1;
  localparam logic [2:0] StatusNoWave    = 3'd2;
  localparam logic [2:0] StatusFmtShort  = 3'd3;
  localparam logic [2:0] StatusTruncated = 3'd4;
  localparam logic [2:0] StatusMissing   = 3'd5;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channels;
    logic [31:0] sampling_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } result_t;

endpackage

@@ sv/wav_header_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser core
// Walks a RIFF/WAVE file byte by byte and reports its format and data chunk.
// ----------------------------------------------------------------------------
// The parser takes one file byte per cycle while the walker is not stalled,
// with no gaps needed between bytes. The byte waits in the input register
// while the combinational chunk walker steps its state and forms the
// result; the new state and the result item are then both registered.
// While a result item waits in the result register the walker stalls, and
// the input stops once the input register is full. At most one result item
// is given per file; the byte marked last always rearms the parser for the
// next file.
module wav_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  file_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] audio_format_o,
  output logic [15:0] channels_o,
  output logic [31:0] sampling_rate_o,
  output logic [31:0] byte_rate_o,
  output logic [15:0] block_align_o,
  output logic [15:0] bits_per_sample_o,
  output logic [31:0] data_offset_o,
  output logic [31:0] data_size_o
);

  wavhp_pkg::item_t   in_item;
  wavhp_pkg::item_t   held_item;
  wavhp_pkg::result_t step_res;
  wavhp_pkg::result_t out_res;
  logic               held_valid;
  logic               out_free;
  logic               step;
  logic               res_valid;

  assign in_item.file_byte = file_byte_i;
  assign in_item.last      = last_i;
  assign step              = held_valid && out_free;

  wavhp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .take_i     (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  wavhp_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (step_res)
  );

  wavhp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign status_o          = out_res.status;
  assign audio_format_o    = out_res.audio_format;
  assign channels_o        = out_res.channels;
  assign sampling_rate_o   = out_res.sampling_rate;
  assign byte_rate_o       = out_res.byte_rate;
  assign block_align_o     = out_res.block_align;
  assign bits_per_sample_o = out_res.bits_per_sample;
  assign data_offset_o     = out_res.data_offset;
  assign data_size_o       = out_res.data_size;

endmodule

@@ sv/wavhp_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser input register
// Holds one incoming item until the walker consumes it.
// ----------------------------------------------------------------------------
module wavhp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wavhp_pkg::item_t in_item_i,
  input  logic            take_i,
  output logic            valid_o,
  output wavhp_pkg::item_t item_o
);

  logic             valid_q;
  logic             valid_d;
  wavhp_pkg::item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ sv/wavhp_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser chunk walker
// Steps the header and chunk state by one byte and forms the result.
// ----------------------------------------------------------------------------
module wavhp_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  wavhp_pkg::item_t  item_i,
  output logic              res_valid_o,
  output wavhp_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PhRiffTag   = 3'd0,
    PhRiffSize  = 3'd1,
    PhWaveTag   = 3'd2,
    PhChunkId   = 3'd3,
    PhChunkSize = 3'd4,
    PhFmtBody   = 3'd5,
    PhSkip      = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [31:0] asm_q, asm_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [32:0] skip_q, skip_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        data_seen_q, data_seen_d;
  logic [63:0] fmt_q, fmt_d;
  logic [63:0] rate_q, rate_d;
  logic [31:0] doff_q, doff_d;
  logic [31:0] dsize_q, dsize_d;
  logic        fin_q, fin_d;

  logic        emit;
  logic [2:0]  status;
  logic [31:0] word;
  logic [2:0]  fmt_idx;
  logic [2:0]  rate_idx;
  logic [32:0] skip_len;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    fbc_d       = fbc_q;
    asm_d       = asm_q;
    tag_d       = tag_q;
    len_d       = len_q;
    skip_d      = skip_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    fmt_d       = fmt_q;
    rate_d      = rate_q;
    doff_d      = doff_q;
    dsize_d     = dsize_q;
    fin_d       = fin_q;
    emit        = 1'b0;
    status      = wavhp_pkg::StatusOk;
    word        = asm_q | ({24'd0, item_i.file_byte} << {fbc_q[1:0], 3'b000});
    fmt_idx     = {fbc_q[3], fbc_q[1:0]};
    rate_idx    = 3'(fbc_q - 4'd4);
    skip_len    = '0;

    if (!fin_q) begin
      pos_d = pos_q + 32'd1;
      unique case (phase_q)
        PhFmtBody: begin
          if (fbc_q >= 4'd4 && fbc_q < 4'd12) begin
            rate_d[{rate_idx, 3'b000} +: 8] = item_i.file_byte;
          end else begin
            fmt_d[{fmt_idx, 3'b000} +: 8] = item_i.file_byte;
          end
          fbc_d = fbc_q + 4'd1;
          if (fbc_q == 4'd15) begin
            fbc_d      = '0;
            fmt_seen_d = 1'b1;
            skip_len   = {1'b0, len_q} - {1'b0, wavhp_pkg::FmtMin} + {32'd0, len_q[0]};
            skip_d     = skip_len;
            phase_d    = (skip_len != '0) ? PhSkip : PhChunkId;
          end
        end
        PhSkip: begin
          skip_d = skip_q - 33'd1;
          if (skip_d == '0) begin
            phase_d = PhChunkId;
          end
        end
        default: begin
          if (fbc_q[1:0] != 2'd3) begin
            asm_d = word;
            fbc_d = fbc_q + 4'd1;
          end else begin
            fbc_d = '0;
            asm_d = '0;
            unique case (phase_q)
              PhRiffTag: begin
                if (word != wavhp_pkg::TagRiff) begin
                  emit   = 1'b1;
                  status = wavhp_pkg::StatusNoRiff;
                end else begin
                  phase_d = PhRiffSize;
                end
              end
              PhRiffSize: begin
                phase_d = PhWaveTag;
              end
              PhWaveTag: begin
                if (word != wavhp_pkg::TagWave) begin
                  emit   = 1'b1;
                  status = wavhp_pkg::StatusNoWave;
                end else begin
                  phase_d = PhChunkId;
                end
              end
              PhChunkId: begin
                tag_d   = word;
                phase_d = PhChunkSize;
              end
              default: begin
                len_d    = word;
                skip_len = {1'b0, word} + {32'd0, word[0]};
                if (tag_q == wavhp_pkg::TagFmt) begin
                  if (word < wavhp_pkg::FmtMin) begin
                    emit   = 1'b1;
                    status = wavhp_pkg::StatusFmtShort;
                  end else begin
                    phase_d = PhFmtBody;
                  end
                end else begin
                  if (tag_q == wavhp_pkg::TagData) begin
                    doff_d      = pos_d;
                    dsize_d     = word;
                    data_seen_d = 1'b1;
                  end
                  if (tag_q == wavhp_pkg::TagData && fmt_seen_q) begin
                    emit   = 1'b1;
                    status = wavhp_pkg::StatusOk;
                  end else begin
                    skip_d  = skip_len;
                    phase_d = (skip_len != '0) ? PhSkip : PhChunkId;
                  end
                end
              end
            endcase
          end
        end
      endcase

      if (item_i.last && !emit) begin
        emit = 1'b1;
        if (phase_d <= PhWaveTag || phase_d == PhFmtBody) begin
          status = wavhp_pkg::StatusTruncated;
        end else if (fmt_seen_d && data_seen_d) begin
          status = wavhp_pkg::StatusOk;
        end else begin
          status = wavhp_pkg::StatusMissing;
        end
      end
      if (emit) begin
        fin_d = 1'b1;
      end
    end

    res_o = '0;
    res_o.status = status;
    if (status == wavhp_pkg::StatusOk) begin
      res_o.audio_format    = fmt_d[15:0];
      res_o.channels        = fmt_d[31:16];
      res_o.sampling_rate   = rate_d[31:0];
      res_o.byte_rate       = rate_d[63:32];
      res_o.block_align     = fmt_d[47:32];
      res_o.bits_per_sample = fmt_d[63:48];
      res_o.data_offset     = doff_d;
      res_o.data_size       = dsize_d;
    end
    res_valid_o = step_i && emit;

    if (item_i.last) begin
      phase_d     = PhRiffTag;
      pos_d       = '0;
      fbc_d       = '0;
      asm_d       = '0;
      tag_d       = '0;
      len_d       = '0;
      skip_d      = '0;
      fmt_seen_d  = 1'b0;
      data_seen_d = 1'b0;
      fmt_d       = '0;
      rate_d      = '0;
      doff_d      = '0;
      dsize_d     = '0;
      fin_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhRiffTag;
      pos_q       <= '0;
      fbc_q       <= '0;
      asm_q       <= '0;
      tag_q       <= '0;
      len_q       <= '0;
      skip_q      <= '0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      fmt_q       <= '0;
      rate_q      <= '0;
      doff_q      <= '0;
      dsize_q     <= '0;
      fin_q       <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      fbc_q       <= fbc_d;
      asm_q       <= asm_d;
      tag_q       <= tag_d;
      len_q       <= len_d;
      skip_q      <= skip_d;
      fmt_seen_q  <= fmt_seen_d;
      data_seen_q <= data_seen_d;
      fmt_q       <= fmt_d;
      rate_q      <= rate_d;
      doff_q      <= doff_d;
      dsize_q     <= dsize_d;
      fin_q       <= fin_d;
    end
  end

endmodule

@@ sv/wavhp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module wavhp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  wavhp_pkg::result_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wavhp_pkg::result_t res_o
);

  logic               valid_q;
  logic               valid_d;
  wavhp_pkg::result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ tb/sv/wavhp_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser result checker
// Follows every accepted file byte with its own copy of the chunk walker,
// queues the header report that each byte should cause, and compares every
// report item given by the parser, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module wavhp_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  file_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] audio_format_i,
  input  logic [15:0] channels_i,
  input  logic [31:0] sampling_rate_i,
  input  logic [31:0] byte_rate_i,
  input  logic [15:0] block_align_i,
  input  logic [15:0] bits_per_sample_i,
  input  logic [31:0] data_offset_i,
  input  logic [31:0] data_size_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    WalkRiffTag,
    WalkRiffSize,
    WalkWaveTag,
    WalkChunkId,
    WalkChunkSize,
    WalkFmtBody,
    WalkSkip
  } walk_phase_e;

  walk_phase_e walk;
  logic [31:0] byte_pos;
  logic [3:0]  byte_idx;
  logic [31:0] word_acc;
  logic [31:0] chunk_id;
  logic [31:0] chunk_size;
  logic [32:0] skip_left;
  logic        fmt_done;
  logic        data_found;
  logic        report_given;
  logic [63:0] fmt_word;
  logic [63:0] rate_word;
  logic [63:0] data_loc;

  wavhp_pkg::result_t header_reports_q[$];

  function automatic void clear_walker();
    walk         = WalkRiffTag;
    byte_pos     = '0;
    byte_idx     = '0;
    word_acc     = '0;
    chunk_id     = '0;
    chunk_size   = '0;
    skip_left    = '0;
    fmt_done     = 1'b0;
    data_found   = 1'b0;
    report_given = 1'b0;
    fmt_word     = '0;
    rate_word    = '0;
    data_loc     = '0;
  endfunction

  function automatic void queue_report(input logic [2:0] status);
    wavhp_pkg::result_t r;
    r = '0;
    r.status = status;
    if (status == wavhp_pkg::StatusOk) begin
      r.audio_format    = fmt_word[15:0];
      r.channels        = fmt_word[31:16];
      r.sampling_rate   = rate_word[31:0];
      r.byte_rate       = rate_word[63:32];
      r.block_align     = fmt_word[47:32];
      r.bits_per_sample = fmt_word[63:48];
      r.data_offset     = data_loc[31:0];
      r.data_size       = data_loc[63:32];
    end
    header_reports_q.push_back(r);
    report_given = 1'b1;
  endfunction

  function automatic void begin_skip(input logic [32:0] n);
    skip_left = n;
    walk = (n != 0) ? WalkSkip : WalkChunkId;
  endfunction

  function automatic void walk_byte(input logic [7:0] b);
    logic [31:0] w;
    logic [3:0]  k;
    if (walk == WalkFmtBody) begin
      k = byte_idx;
      if (k < 4) fmt_word[k*8 +: 8] = b;
      else if (k < 12) rate_word[(k-4)*8 +: 8] = b;
      else fmt_word[(k-8)*8 +: 8] = b;
      byte_idx = k + 4'd1;
      if (k == 4'd15) begin
        fmt_done = 1'b1;
        begin_skip({1'b0, chunk_size - wavhp_pkg::FmtMin} + chunk_size[0]);
      end
    end else if (walk == WalkSkip) begin
      skip_left = skip_left - 33'd1;
      if (skip_left == 0) walk = WalkChunkId;
    end else begin
      word_acc = word_acc | ({24'd0, b} << (byte_idx[1:0] * 8));
      if (byte_idx < 3) begin
        byte_idx = byte_idx + 4'd1;
      end else begin
        byte_idx = '0;
        w = word_acc;
        word_acc = '0;
        case (walk)
          WalkRiffTag: begin
            if (w != wavhp_pkg::TagRiff) queue_report(wavhp_pkg::StatusNoRiff);
            else walk = WalkRiffSize;
          end
          WalkRiffSize: begin
            walk = WalkWaveTag;
          end
          WalkWaveTag: begin
            if (w != wavhp_pkg::TagWave) queue_report(wavhp_pkg::StatusNoWave);
            else walk = WalkChunkId;
          end
          WalkChunkId: begin
            chunk_id = w;
            walk = WalkChunkSize;
          end
          default: begin
            chunk_size = w;
            if (chunk_id == wavhp_pkg::TagFmt) begin
              if (w < wavhp_pkg::FmtMin) queue_report(wavhp_pkg::StatusFmtShort);
              else walk = WalkFmtBody;
            end else begin
              if (chunk_id == wavhp_pkg::TagData) begin
                data_loc = {w, byte_pos};
                data_found = 1'b1;
              end
              if (chunk_id == wavhp_pkg::TagData && fmt_done) begin
                queue_report(wavhp_pkg::StatusOk);
              end else begin
                begin_skip({1'b0, w} + w[0]);
              end
            end
          end
        endcase
      end
    end
  endfunction

  function automatic void accept_byte(input logic [7:0] b, input logic l);
    if (!report_given) begin
      byte_pos = byte_pos + 32'd1;
      walk_byte(b);
    end
    if (l) begin
      if (!report_given) begin
        if (walk <= WalkWaveTag || walk == WalkFmtBody) begin
          queue_report(wavhp_pkg::StatusTruncated);
        end else if (fmt_done && data_found) begin
          queue_report(wavhp_pkg::StatusOk);
        end else begin
          queue_report(wavhp_pkg::StatusMissing);
        end
      end
      clear_walker();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= 60) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wavhp_pkg::result_t want;
    if (!rst_ni) begin
      clear_walker();
      header_reports_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) accept_byte(file_byte_i, last_i);
      if (out_valid_i && out_ready_i) begin
        if (header_reports_q.size() == 0) begin
          report_mismatch("result item given with none expected");
        end else begin
          want = header_reports_q.pop_front();
          check_field("status", status_i, want.status);
          check_field("audio_format", audio_format_i, want.audio_format);
          check_field("channels", channels_i, want.channels);
          check_field("sampling_rate", sampling_rate_i, want.sampling_rate);
          check_field("byte_rate", byte_rate_i, want.byte_rate);
          check_field("block_align", block_align_i, want.block_align);
          check_field("bits_per_sample", bits_per_sample_i, want.bits_per_sample);
          check_field("data_offset", data_offset_i, want.data_offset);
          check_field("data_size", data_size_i, want.data_size);
        end
      end
    end
    pending_o = header_reports_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Streams directed and random WAV files, well-formed and broken, through the
// parser with random gaps on both channels; a checker predicts the reports.
// ----------------------------------------------------------------------------
module tb;

  localparam int IdleLimit   = 4000;
  localparam int RandomBytes = 1600;
  localparam int MinFiles    = 36;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  file_byte = 8'd0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] audio_format;
  logic [15:0] channels;
  logic [31:0] sampling_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [31:0] data_offset;
  logic [31:0] data_size;

  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  int         ready_hold = 0;
  int         bytes_sent = 0;
  int         files_sent = 0;
  bit         no_gaps = 1'b0;
  logic [7:0] file_q[$];

  always #5 clk = ~clk;

  wav_header_parser_core DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .file_byte_i      (file_byte),
    .last_i           (last),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .audio_format_o   (audio_format),
    .channels_o       (channels),
    .sampling_rate_o  (sampling_rate),
    .byte_rate_o      (byte_rate),
    .block_align_o    (block_align),
    .bits_per_sample_o(bits_per_sample),
    .data_offset_o    (data_offset),
    .data_size_o      (data_size)
  );

  wavhp_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .file_byte_i      (file_byte),
    .last_i           (last),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .audio_format_i   (audio_format),
    .channels_i       (channels),
    .sampling_rate_i  (sampling_rate),
    .byte_rate_i      (byte_rate),
    .block_align_i    (block_align),
    .bits_per_sample_i(bits_per_sample),
    .data_offset_i    (data_offset),
    .data_size_i      (data_size),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (!out_ready || no_gaps || $urandom_range(0, 9) < 6) begin
      out_ready = 1'b1;
      ready_hold = $urandom_range(0, 15);
    end else begin
      out_ready = 1'b0;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[wav_header_parser_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[i*8 +: 8]);
  endfunction

  function automatic void put_random(input int n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function automatic void put_chunk(input logic [31:0] id, input int unsigned size);
    put_word(id);
    put_word(size);
    put_random(size + size % 2);
  endfunction

  function automatic void put_riff_header();
    put_word(wavhp_pkg::TagRiff);
    put_word($urandom);
    put_word(wavhp_pkg::TagWave);
  endfunction

  function automatic logic [31:0] one_bit_off(input logic [31:0] tag);
    return tag ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] stray_chunk_id();
    logic [31:0] id;
    if ($urandom_range(0, 1) == 0) begin
      id = one_bit_off($urandom_range(0, 1) ? wavhp_pkg::TagData : wavhp_pkg::TagFmt);
    end else begin
      do id = $urandom; while (id == wavhp_pkg::TagFmt || id == wavhp_pkg::TagData);
    end
    return id;
  endfunction

  function automatic logic [31:0] pick_data_size();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 64);
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void build_random_file();
    int cut;
    if ($urandom_range(0, 99) < 65) begin
      put_riff_header();
      repeat ($urandom_range(0, 2)) put_chunk(stray_chunk_id(), $urandom_range(0, 9));
      if ($urandom_range(0, 9) == 0) put_chunk(wavhp_pkg::TagData, $urandom_range(0, 7));
      repeat (1 + ($urandom_range(0, 9) == 0)) begin
        put_chunk(wavhp_pkg::TagFmt, 16 + $urandom_range(0, 5));
      end
      if ($urandom_range(0, 3) == 0) put_chunk(stray_chunk_id(), $urandom_range(0, 5));
      put_word(wavhp_pkg::TagData);
      put_word(pick_data_size());
      put_random($urandom_range(0, 6));
    end else begin
      case ($urandom_range(0, 7))
        0: put_random($urandom_range(1, 24));
        1: begin
          put_word(one_bit_off(wavhp_pkg::TagRiff));
          put_random($urandom_range(0, 8));
        end
        2: begin
          put_word(wavhp_pkg::TagRiff);
          put_random(4);
          put_word(one_bit_off(wavhp_pkg::TagWave));
          put_random($urandom_range(0, 8));
        end
        3: begin
          put_riff_header();
          put_word(wavhp_pkg::TagFmt);
          put_word($urandom_range(0, 15));
          put_random($urandom_range(0, 8));
        end
        4: begin
          put_riff_header();
          put_chunk(wavhp_pkg::TagFmt, 16 + $urandom_range(0, 5));
          repeat ($urandom_range(0, 2)) put_chunk(stray_chunk_id(), $urandom_range(0, 7));
        end
        5: begin
          put_riff_header();
          put_chunk(wavhp_pkg::TagData, $urandom_range(0, 7));
          put_chunk(wavhp_pkg::TagFmt, 16 + $urandom_range(0, 5));
          if ($urandom_range(0, 1) == 0) put_chunk(stray_chunk_id(), $urandom_range(0, 5));
        end
        6: begin
          put_riff_header();
          put_chunk(wavhp_pkg::TagData, $urandom_range(0, 7));
        end
        default: begin
          put_riff_header();
          if ($urandom_range(0, 1) == 0) put_chunk(wavhp_pkg::TagFmt, 16);
          put_word(stray_chunk_id());
          put_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom);
          put_random($urandom_range(0, 10));
        end
      endcase
    end
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    file_byte = b;
    last = l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_file();
    no_gaps = ($urandom_range(0, 4) == 0);
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    bytes_sent += file_q.size();
    files_sent++;
    file_q.delete();
    if (files_sent == 1 || $urandom_range(0, 4) == 0) begin
      while (pending != 0) @(negedge clk);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Plain PCM stereo file with a few audio bytes after the data header.
    put_riff_header();
    put_word(wavhp_pkg::TagFmt);
    put_word(32'd16);
    put_word({16'd2, 16'd1});
    put_word(32'd44100);
    put_word(32'd176400);
    put_word({16'd16, 16'd4});
    put_word(wavhp_pkg::TagData);
    put_word(32'd8);
    put_random(8);
    send_file();

    // All format fields and the data size at their largest; last on the size.
    put_riff_header();
    put_word(wavhp_pkg::TagFmt);
    put_word(32'd16);
    repeat (4) put_word(32'hFFFF_FFFF);
    put_word(wavhp_pkg::TagData);
    put_word(32'hFFFF_FFFF);
    send_file();

    // All fields zero, data size zero, odd stray chunk with its pad byte.
    put_riff_header();
    put_chunk(stray_chunk_id(), 3);
    put_word(wavhp_pkg::TagFmt);
    put_word(32'd17);
    repeat (4) put_word(32'd0);
    put_random(2);
    put_word(wavhp_pkg::TagData);
    put_word(32'd0);
    put_random(3);
    send_file();

    put_word(one_bit_off(wavhp_pkg::TagRiff));
    send_file();

    put_word(wavhp_pkg::TagRiff);
    put_random(4);
    put_word(one_bit_off(wavhp_pkg::TagWave));
    send_file();

    put_riff_header();
    put_word(wavhp_pkg::TagFmt);
    put_word(32'd15);
    put_random(4);
    send_file();

    // Last byte on the very first byte of a file.
    file_q.push_back(wavhp_pkg::TagRiff[7:0]);
    send_file();

    // Last byte completes a good WAVE tag.
    put_riff_header();
    send_file();

    // Fmt body cut short by the last byte.
    put_riff_header();
    put_word(wavhp_pkg::TagFmt);
    put_word(32'd16);
    put_random(7);
    send_file();

    // Data chunk ahead of the fmt chunk, ending on a chunk boundary.
    put_riff_header();
    put_chunk(wavhp_pkg::TagData, 5);
    put_chunk(wavhp_pkg::TagFmt, 18);
    send_file();

    // A second fmt chunk replaces the first.
    put_riff_header();
    put_chunk(wavhp_pkg::TagFmt, 16);
    put_chunk(wavhp_pkg::TagFmt, 16);
    put_word(wavhp_pkg::TagData);
    put_word($urandom);
    send_file();

    // Fmt without data, then data without fmt.
    put_riff_header();
    put_chunk(wavhp_pkg::TagFmt, 16);
    send_file();
    put_riff_header();
    put_chunk(wavhp_pkg::TagData, 2);
    send_file();

    // Stray chunk declaring the largest size, ended inside its body.
    put_riff_header();
    put_chunk(wavhp_pkg::TagFmt, 16);
    put_word(stray_chunk_id());
    put_word(32'hFFFF_FFFF);
    put_random(5);
    send_file();

    while (bytes_sent < RandomBytes || files_sent < MinFiles) begin
      build_random_file();
      send_file();
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("[wav_header_parser_core] OK");
    end else begin
      $display("[wav_header_parser_core] ERROR");
    end
    $finish;
  end

endmodule
